/* rtl/core/worst_fit_partition_allocator_assert.svh */
// Assertion macros used by the checker file.
`ifndef WORST_FIT_PARTITION_ALLOCATOR_ASSERT_SVH
`define WORST_FIT_PARTITION_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define WFPA_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("wfpa assertion failed");

// Next-cycle implication, checked outside reset.
`define WFPA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("wfpa assertion failed");

`endif

/* rtl/core/wfpa_pkg.sv */
`default_nettype none

package wfpa_pkg;

    localparam int MAX_BLOCKS = 32;
    localparam int BLK_W      = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int CNT_W      = $clog2(MAX_BLOCKS + 1);

    localparam int TYPE_W = 1;
    localparam int IDX_W  = 5;
    localparam int SIZE_W = 16;
    localparam int PNUM_W = 16;
    localparam int SUM_W  = 21;
    localparam int CFG_W  = 6;

    localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(32);
    localparam logic [SUM_W-1:0] SUM_MAX   = {SUM_W{1'b1}};

    // request kinds
    localparam logic [TYPE_W-1:0] REQ_LOAD  = 1'b0;
    localparam logic [TYPE_W-1:0] REQ_ALLOC = 1'b1;

    typedef struct packed {
        logic              is_alloc;
        logic [BLK_W-1:0]  idx;
        logic [SIZE_W-1:0] size;
        logic [PNUM_W-1:0] pnum;
    } t_cmd;

endpackage

`default_nettype wire

/* rtl/core/wfpa_if.sv */
`default_nettype none

interface wfpa_req_if;
    logic                       valid;
    logic                       ready;
    logic [wfpa_pkg::TYPE_W-1:0] req_type;
    logic [wfpa_pkg::IDX_W-1:0]  block_index;
    logic [wfpa_pkg::SIZE_W-1:0] size_value;
    logic [wfpa_pkg::PNUM_W-1:0] process_number;

    modport source (output valid, req_type, block_index, size_value, process_number,
                    input ready);
    modport sink   (input valid, req_type, block_index, size_value, process_number,
                    output ready);
endinterface

interface wfpa_rsp_if;
    logic                       valid;
    logic                       ready;
    logic                       granted;
    logic [wfpa_pkg::IDX_W-1:0]  chosen_block;
    logic [wfpa_pkg::SIZE_W-1:0] fragment;
    logic [wfpa_pkg::SUM_W-1:0]  used_memory;
    logic [wfpa_pkg::SUM_W-1:0]  total_memory;
    logic [wfpa_pkg::PNUM_W-1:0] process_echo;

    modport source (output valid, granted, chosen_block, fragment, used_memory,
                    total_memory, process_echo, input ready);
    modport sink   (input valid, granted, chosen_block, fragment, used_memory,
                    total_memory, process_echo, output ready);
endinterface

`default_nettype wire

/* rtl/core/wfpa_front.sv */
`default_nettype none

// Takes request transactions, drops out-of-range loads, registers the command.
module wfpa_front (
    input  wire              i_clk,
    input  wire              i_rst_n,
    wfpa_req_if.sink         i_req,
    output logic             o_cmd_valid,
    output wfpa_pkg::t_cmd   o_cmd,
    input  wire              i_cmd_ready
);

    logic           r_valid;
    wfpa_pkg::t_cmd r_cmd;
    logic           take;
    logic           keep;

    assign i_req.ready = !r_valid || i_cmd_ready;
    assign take        = i_req.valid && i_req.ready;
    // a load beyond the table changes nothing
    assign keep        = (i_req.req_type == wfpa_pkg::REQ_ALLOC) ||
                         (32'(i_req.block_index) < wfpa_pkg::MAX_BLOCKS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (take) begin
            r_valid <= keep;
        end else if (i_cmd_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_cmd.is_alloc <= (i_req.req_type == wfpa_pkg::REQ_ALLOC);
            r_cmd.idx      <= wfpa_pkg::BLK_W'(i_req.block_index);
            r_cmd.size     <= i_req.size_value;
            r_cmd.pnum     <= i_req.process_number;
        end
    end

    assign o_cmd_valid = r_valid;
    assign o_cmd       = r_cmd;

endmodule

`default_nettype wire

/* rtl/core/wfpa_queue.sv */
`default_nettype none

// Two-entry command queue between front and back.
module wfpa_queue (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_push_valid,
    input  wfpa_pkg::t_cmd   i_push_cmd,
    output logic             o_push_ready,
    output logic             o_pop_valid,
    output wfpa_pkg::t_cmd   o_pop_cmd,
    input  wire              i_pop_ready
);

    wfpa_pkg::t_cmd r_slot [2];
    logic           r_wr_ptr;
    logic           r_rd_ptr;
    logic [1:0]     r_count;
    logic           push;
    logic           pop;

    assign o_push_ready = (r_count != 2'd2);
    assign o_pop_valid  = (r_count != 2'd0);
    assign o_pop_cmd    = r_slot[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            if (push && !pop) begin
                r_count <= r_count + 2'd1;
            end else if (pop && !push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_slot[r_wr_ptr] <= i_push_cmd;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/wfpa_back.sv */
`default_nettype none

// Executes commands: size table, taken marks, sums, worst-fit scan, result register.
module wfpa_back (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire [wfpa_pkg::CNT_W-1:0]   i_limit,
    input  wire                         i_cmd_valid,
    input  wfpa_pkg::t_cmd              i_cmd,
    output logic                        o_cmd_ready,
    wfpa_rsp_if.source                  o_rsp
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_LD_RD = 3'd1;
    localparam logic [2:0] S_LD_WR = 3'd2;
    localparam logic [2:0] S_SCAN  = 3'd3;
    localparam logic [2:0] S_DRAIN = 3'd4;
    localparam logic [2:0] S_FIN   = 3'd5;

    logic [2:0]                    r_state;
    wfpa_pkg::t_cmd                r_cmd;
    logic [wfpa_pkg::CNT_W-1:0]    r_cnt;
    logic                          r_cmp_vld;
    logic [wfpa_pkg::BLK_W-1:0]    r_cmp_idx;
    logic                          r_found;
    logic [wfpa_pkg::BLK_W-1:0]    r_best;
    logic [wfpa_pkg::SIZE_W-1:0]   r_best_size;
    logic [wfpa_pkg::SUM_W-1:0]    r_used;
    logic [wfpa_pkg::SUM_W-1:0]    r_total;

    // size table: memory plus per-entry valid bits (unwritten reads as zero)
    logic [wfpa_pkg::SIZE_W-1:0]   mem [wfpa_pkg::MAX_BLOCKS];
    logic [wfpa_pkg::MAX_BLOCKS-1:0] r_vld;
    logic [wfpa_pkg::MAX_BLOCKS-1:0] r_taken;
    logic [wfpa_pkg::SIZE_W-1:0]   r_rd_size;
    logic                          r_rd_hit;
    logic                          r_rd_taken;

    logic                          r_out_valid;
    logic                          r_out_granted;
    logic [wfpa_pkg::IDX_W-1:0]    r_out_block;
    logic [wfpa_pkg::SIZE_W-1:0]   r_out_frag;
    logic [wfpa_pkg::SUM_W-1:0]    r_out_used;
    logic [wfpa_pkg::SUM_W-1:0]    r_out_total;
    logic [wfpa_pkg::PNUM_W-1:0]   r_out_pnum;

    logic [wfpa_pkg::BLK_W-1:0]    rd_addr;
    logic [wfpa_pkg::SIZE_W-1:0]   rd_size;
    logic                          fits;
    logic                          out_free;
    logic                          out_load;
    logic                          pop;
    logic                          mem_we;
    logic [wfpa_pkg::SUM_W:0]      used_wide;
    logic [wfpa_pkg::SUM_W-1:0]    n_used;

    assign o_cmd_ready = (r_state == S_IDLE);
    assign pop         = i_cmd_valid && o_cmd_ready;
    assign out_free    = !r_out_valid || o_rsp.ready;
    assign out_load    = (r_state == S_FIN) && out_free;
    assign rd_addr     = (r_state == S_LD_RD) ? r_cmd.idx : r_cnt[wfpa_pkg::BLK_W-1:0];
    assign rd_size     = r_rd_hit ? r_rd_size : '0;
    assign fits        = r_cmp_vld && !r_rd_taken && (rd_size >= r_cmd.size) &&
                         (!r_found || rd_size >= r_best_size);
    assign mem_we      = (r_state == S_LD_WR);

    assign used_wide   = (wfpa_pkg::SUM_W+1)'(r_used) + (wfpa_pkg::SUM_W+1)'(r_cmd.size);
    assign n_used      = used_wide[wfpa_pkg::SUM_W] ? wfpa_pkg::SUM_MAX
                                                   : used_wide[wfpa_pkg::SUM_W-1:0];

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[r_cmd.idx] <= r_cmd.size;
        end
        r_rd_size  <= mem[rd_addr];
        r_rd_hit   <= r_vld[rd_addr];
        r_rd_taken <= r_taken[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_vld       <= '0;
            r_taken     <= '0;
            r_used      <= '0;
            r_total     <= '0;
            r_cmp_vld   <= 1'b0;
            r_found     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    r_cmp_vld <= 1'b0;
                    r_found   <= 1'b0;
                    if (pop) begin
                        if (!i_cmd.is_alloc) begin
                            r_state <= S_LD_RD;
                        end else if (i_limit == '0) begin
                            r_state <= S_FIN;
                        end else begin
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_LD_RD: begin
                    r_state <= S_LD_WR;
                end
                S_LD_WR: begin
                    r_vld[r_cmd.idx]   <= 1'b1;
                    r_taken[r_cmd.idx] <= 1'b0;
                    r_total <= r_total - wfpa_pkg::SUM_W'(rd_size)
                                       + wfpa_pkg::SUM_W'(r_cmd.size);
                    r_state <= S_IDLE;
                end
                S_SCAN: begin
                    r_cmp_vld <= 1'b1;
                    if (fits) begin
                        r_found <= 1'b1;
                    end
                    if ((r_cnt + wfpa_pkg::CNT_W'(1)) == i_limit) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    r_cmp_vld <= 1'b0;
                    if (fits) begin
                        r_found <= 1'b1;
                    end
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    if (out_free) begin
                        if (r_found) begin
                            r_taken[r_best] <= 1'b1;
                            r_used          <= n_used;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // datapath registers, no reset
    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_cmd <= i_cmd;
            r_cnt <= '0;
        end else if (r_state == S_SCAN) begin
            r_cnt <= r_cnt + wfpa_pkg::CNT_W'(1);
        end
        r_cmp_idx <= r_cnt[wfpa_pkg::BLK_W-1:0];
        if (fits) begin
            r_best      <= r_cmp_idx;
            r_best_size <= rd_size;
        end
        if (r_state == S_FIN && out_free) begin
            r_out_granted <= r_found;
            r_out_block   <= r_found ? wfpa_pkg::IDX_W'(r_best) : '0;
            r_out_frag    <= r_found ? (r_best_size - r_cmd.size) : '0;
            r_out_used    <= r_found ? n_used : r_used;
            r_out_total   <= r_total;
            r_out_pnum    <= r_cmd.pnum;
        end
    end

    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.granted      = r_out_granted;
    assign o_rsp.chosen_block = r_out_block;
    assign o_rsp.fragment     = r_out_frag;
    assign o_rsp.used_memory  = r_out_used;
    assign o_rsp.total_memory = r_out_total;
    assign o_rsp.process_echo = r_out_pnum;

endmodule

`default_nettype wire

/* rtl/core/worst_fit_partition_allocator.sv */
`default_nettype none

// Channel   Dir  Handshake      Payload
// i_req     in   valid/ready    req_type, block_index, size_value, process_number
// o_rsp     out  valid/ready    granted, chosen_block, fragment, used_memory,
//                               total_memory, process_echo
// i_cfg_*   in   write enable   blocks_in_use (6 bits)
//
// Load transaction: table read, then table write and sum update in the back end.
// Allocate transaction: scans limit = min(blocks_in_use, MAX_BLOCKS) entries,
// then drains, then waits for a free output register; zero limit skips both;
// the scan reads one table entry per cycle through the single memory read port.
// Front register and a two-entry queue let requests be taken while the back end
// scans or while a result waits in the output register.
// Synchronous active-low reset clears the table valid bits, taken marks and sums
// at once; no clearing pass.
module worst_fit_partition_allocator (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    wfpa_req_if.sink                     i_req,
    wfpa_rsp_if.source                   o_rsp,
    input  wire                          i_cfg_we,
    input  wire [wfpa_pkg::CFG_W-1:0]    i_cfg_data
);

    // blocks_in_use register
    logic [wfpa_pkg::CFG_W-1:0] r_blocks;
    logic [wfpa_pkg::CNT_W-1:0] limit;

    logic           fr_valid;
    wfpa_pkg::t_cmd fr_cmd;
    logic           fr_ready;
    logic           q_valid;
    wfpa_pkg::t_cmd q_cmd;
    logic           q_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blocks <= wfpa_pkg::CFG_RESET;
        end else if (i_cfg_we) begin
            r_blocks <= i_cfg_data;
        end
    end

    // scan length clamps at the table depth
    always_comb begin
        if (32'(r_blocks) > wfpa_pkg::MAX_BLOCKS) begin
            limit = wfpa_pkg::CNT_W'(wfpa_pkg::MAX_BLOCKS);
        end else begin
            limit = wfpa_pkg::CNT_W'(r_blocks);
        end
    end

    wfpa_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .o_cmd_valid (fr_valid),
        .o_cmd       (fr_cmd),
        .i_cmd_ready (fr_ready)
    );

    wfpa_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (fr_valid),
        .i_push_cmd   (fr_cmd),
        .o_push_ready (fr_ready),
        .o_pop_valid  (q_valid),
        .o_pop_cmd    (q_cmd),
        .i_pop_ready  (q_ready)
    );

    wfpa_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_limit     (limit),
        .i_cmd_valid (q_valid),
        .i_cmd       (q_cmd),
        .o_cmd_ready (q_ready),
        .o_rsp       (o_rsp)
    );

endmodule

`default_nettype wire

/* rtl/core/wfpa_checker.sv */
`default_nettype none

`include "worst_fit_partition_allocator_assert.svh"

module wfpa_checker (
    input wire                          i_clk,
    input wire                          i_rst_n,
    input wire                          i_rsp_valid,
    input wire                          i_rsp_ready,
    input wire                          i_granted,
    input wire [wfpa_pkg::IDX_W-1:0]    i_chosen_block,
    input wire [wfpa_pkg::SIZE_W-1:0]   i_fragment,
    input wire [wfpa_pkg::SUM_W-1:0]    i_used_memory
);

    // result held until taken
    `WFPA_ASSERT_NEXT(a_rsp_hold, i_clk, i_rst_n, i_rsp_valid && !i_rsp_ready, i_rsp_valid)
    // stalled result keeps its used figure
    `WFPA_ASSERT_NEXT(a_rsp_stable, i_clk, i_rst_n, i_rsp_valid && !i_rsp_ready, $stable(i_used_memory))
    // refusal reports no block and no fragment
    `WFPA_ASSERT_SAME(a_refuse_zero, i_clk, i_rst_n, i_rsp_valid && !i_granted, i_chosen_block == '0 && i_fragment == '0)
    // used memory never shrinks between results
    `WFPA_ASSERT_SAME(a_used_mono, i_clk, i_rst_n, i_rsp_valid && $past(i_rsp_valid) && $past(i_rst_n), i_used_memory >= $past(i_used_memory))

endmodule

bind worst_fit_partition_allocator wfpa_checker u_wfpa_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_rsp_valid    (o_rsp.valid),
    .i_rsp_ready    (o_rsp.ready),
    .i_granted      (o_rsp.granted),
    .i_chosen_block (o_rsp.chosen_block),
    .i_fragment     (o_rsp.fragment),
    .i_used_memory  (o_rsp.used_memory)
);

`default_nettype wire

/* test/worst_fit_partition_allocator_tb.sv */
`timescale 1ns / 100ps

module worst_fit_partition_allocator_tb;

    localparam int HALF_PERIOD = 10;
    // Loads give no result, so up to four of them (front register, queue, back end)
    // may still be in flight after the last allocate result.
    localparam int SETTLE_CYCLES = 160;
    // Cycles without any transaction on either channel before giving up.
    localparam int WATCHDOG_LIMIT = 5000;

    // One allocate result as the block should report it.
    typedef struct packed {
        logic                        granted;
        logic [wfpa_pkg::IDX_W-1:0]  block;
        logic [wfpa_pkg::SIZE_W-1:0] frag;
        logic [wfpa_pkg::SUM_W-1:0]  used;
        logic [wfpa_pkg::SUM_W-1:0]  total;
        logic [wfpa_pkg::PNUM_W-1:0] pnum;
    } t_alloc_result;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n;
    logic                       i_cfg_we;
    logic [wfpa_pkg::CFG_W-1:0] i_cfg_data;

    wfpa_req_if req_ch();
    wfpa_rsp_if rsp_ch();

    worst_fit_partition_allocator DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (req_ch),
        .o_rsp      (rsp_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data)
    );

    // Shadow of the partition table, the running sums and the scan length.
    logic [wfpa_pkg::SIZE_W-1:0] blk_size [wfpa_pkg::MAX_BLOCKS];
    bit                          blk_taken [wfpa_pkg::MAX_BLOCKS];
    logic [wfpa_pkg::SUM_W-1:0]  used_total;
    logic [wfpa_pkg::SUM_W-1:0]  mem_total;
    logic [wfpa_pkg::CFG_W-1:0]  block_count;

    // Allocate results still owed by the block, oldest first.
    t_alloc_result pending_allocs[$];

    int unsigned error_count  = 0;
    int unsigned quiet_cycles = 0;
    int unsigned rsp_hold     = 0;
    // When set, neither side idles: back-to-back transactions.
    bit          steady       = 1'b0;

    always begin
        #HALF_PERIOD i_clk = 1'b1;
        #HALF_PERIOD i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    function automatic void reset_shadow();
        for (int j = 0; j < wfpa_pkg::MAX_BLOCKS; j++) begin
            blk_size[j]  = '0;
            blk_taken[j] = 1'b0;
        end
        used_total  = '0;
        mem_total   = '0;
        block_count = wfpa_pkg::CFG_RESET;
    endfunction

    // Applies one accepted request to the shadow; an allocate queues its result.
    function automatic void predict_request(input wfpa_pkg::t_cmd cmd);
        int unsigned                 limit;
        bit                          found;
        int unsigned                 best;
        logic [wfpa_pkg::SIZE_W-1:0] best_size;
        logic [wfpa_pkg::SUM_W:0]    used_sum;
        t_alloc_result               r;

        if (!cmd.is_alloc) begin
            // Reloading a block frees it; the total tracks the size swap, mod 2^21.
            mem_total          = mem_total - wfpa_pkg::SUM_W'(blk_size[cmd.idx])
                                           + wfpa_pkg::SUM_W'(cmd.size);
            blk_size[cmd.idx]  = cmd.size;
            blk_taken[cmd.idx] = 1'b0;
            return;
        end

        limit = (block_count > wfpa_pkg::MAX_BLOCKS) ? wfpa_pkg::MAX_BLOCKS
                                                     : int'(block_count);
        found     = 1'b0;
        best      = 0;
        best_size = '0;
        // Largest free block that fits; >= so the highest index wins a tie.
        for (int unsigned j = 0; j < limit; j++) begin
            if (!blk_taken[j] && blk_size[j] >= cmd.size &&
                (!found || blk_size[j] >= best_size)) begin
                found     = 1'b1;
                best      = j;
                best_size = blk_size[j];
            end
        end

        r = '0;
        if (found) begin
            blk_taken[best] = 1'b1;
            r.granted = 1'b1;
            r.block   = wfpa_pkg::IDX_W'(best);
            r.frag    = best_size - cmd.size;
            // used memory never drops and saturates at the top of its range
            used_sum   = {1'b0, used_total} + (wfpa_pkg::SUM_W+1)'(cmd.size);
            used_total = (used_sum > wfpa_pkg::SUM_MAX) ? wfpa_pkg::SUM_MAX
                                                        : used_sum[wfpa_pkg::SUM_W-1:0];
        end
        r.used  = used_total;
        r.total = mem_total;
        r.pnum  = cmd.pnum;
        pending_allocs.push_back(r);
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    function automatic int unsigned draw_gap();
        return steady ? 0 : $urandom_range(0, 4);
    endfunction

    function automatic wfpa_pkg::t_cmd load_cmd(input logic [wfpa_pkg::IDX_W-1:0]  idx,
                                                input logic [wfpa_pkg::SIZE_W-1:0] size);
        wfpa_pkg::t_cmd c = '0;
        c.is_alloc = 1'b0;
        c.idx      = idx;
        c.size     = size;
        c.pnum     = wfpa_pkg::PNUM_W'($urandom);
        return c;
    endfunction

    // block_index is ignored by an allocate, so it carries random bits
    function automatic wfpa_pkg::t_cmd alloc_cmd(input logic [wfpa_pkg::SIZE_W-1:0] size,
                                                 input logic [wfpa_pkg::PNUM_W-1:0] pnum);
        wfpa_pkg::t_cmd c = '0;
        c.is_alloc = 1'b1;
        c.idx      = wfpa_pkg::IDX_W'($urandom);
        c.size     = size;
        c.pnum     = pnum;
        return c;
    endfunction

    // Sends one request transaction after a random idle spell. Valid is left high
    // on return, so a following item with no gap goes out back to back.
    task automatic send_item(input wfpa_pkg::t_cmd cmd);
        int unsigned gap;

        gap = draw_gap();
        if (gap != 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_ch.valid          <= 1'b1;
        req_ch.req_type       <= cmd.is_alloc ? wfpa_pkg::REQ_ALLOC : wfpa_pkg::REQ_LOAD;
        req_ch.block_index    <= cmd.idx;
        req_ch.size_value     <= cmd.size;
        req_ch.process_number <= cmd.pnum;
        do @(posedge i_clk); while (!req_ch.ready);
        predict_request(cmd);
    endtask

    // Quiesces the block: every owed result back and trailing loads retired.
    task automatic wait_idle();
        req_ch.valid <= 1'b0;
        while (pending_allocs.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_block_count(input logic [wfpa_pkg::CFG_W-1:0] value);
        wait_idle();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        block_count  = value;
    endtask

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t ns: %s mismatch, got %0d expected %0d", $time, what, got, want);
        error_count++;
    endtask

    task automatic check_result();
        t_alloc_result want;

        if (pending_allocs.size() == 0) begin
            report_mismatch("unexpected result", rsp_ch.process_echo, 0);
            return;
        end
        want = pending_allocs.pop_front();
        if (rsp_ch.granted !== want.granted)
            report_mismatch("granted", rsp_ch.granted, want.granted);
        if (rsp_ch.chosen_block !== want.block)
            report_mismatch("chosen_block", rsp_ch.chosen_block, want.block);
        if (rsp_ch.fragment !== want.frag)
            report_mismatch("fragment", rsp_ch.fragment, want.frag);
        if (rsp_ch.used_memory !== want.used)
            report_mismatch("used_memory", rsp_ch.used_memory, want.used);
        if (rsp_ch.total_memory !== want.total)
            report_mismatch("total_memory", rsp_ch.total_memory, want.total);
        if (rsp_ch.process_echo !== want.pnum)
            report_mismatch("process_echo", rsp_ch.process_echo, want.pnum);
    endtask

    // Result side: take a transaction, then hold ready low for a random spell.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_ch.ready <= 1'b0;
            rsp_hold      = 0;
        end else begin
            if (rsp_ch.ready && rsp_ch.valid) begin
                check_result();
                rsp_hold = draw_gap();
            end else if (rsp_hold != 0) begin
                rsp_hold--;
            end
            rsp_ch.ready <= (rsp_hold == 0);
        end
    end

    // Watchdog: a long run with no transaction on either channel is a hang.
    always @(posedge i_clk) begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Fresh table: every block is free with size zero, so a zero-size process
    // fits and the tie goes to the top block; anything larger fits nowhere.
    task automatic test_empty_table();
        send_item(alloc_cmd(16'h0000, 16'h0000));
        send_item(alloc_cmd(16'h0001, 16'hFFFF));
    endtask

    // Worst-fit order, ties, exact fit, a miss, and reloading a taken block.
    task automatic test_worst_fit_choice();
        send_item(load_cmd(5'd0, 16'hFFFF));
        send_item(load_cmd(5'd31, 16'hFFFF));
        send_item(load_cmd(5'd5, 16'd1000));
        send_item(alloc_cmd(16'hFFFF, 16'h1234));   // tie: block 31
        send_item(alloc_cmd(16'hFFFF, 16'hEDCB));   // then block 0
        send_item(alloc_cmd(16'd1001, 16'h0001));   // nothing large enough
        send_item(alloc_cmd(16'd1000, 16'h0002));   // exact fit, no fragment
        send_item(load_cmd(5'd31, 16'd300));        // frees a taken block
        send_item(alloc_cmd(16'h0000, 16'h0003));
    endtask

    // Scan length at zero, above the table size, and at a single block.
    task automatic test_block_count_limits();
        write_block_count(6'd0);
        send_item(alloc_cmd(16'h0000, 16'h00FF));   // nothing scanned
        write_block_count(6'd63);
        send_item(load_cmd(5'd16, 16'hAAAA));
        send_item(alloc_cmd(16'h5555, 16'hFF00));
        write_block_count(6'd1);
        send_item(load_cmd(5'd0, 16'h8000));
        send_item(alloc_cmd(16'h7FFF, 16'h5A5A));
        send_item(alloc_cmd(16'h0000, 16'hA5A5));   // block 0 now taken
        write_block_count(wfpa_pkg::CFG_RESET);
    endtask

    // One setting of the scan length with a random mix of loads and allocates.
    // Request sizes stay mostly small so the used sum does not saturate early;
    // block sizes favour a few repeated values to provoke ties.
    task automatic run_random_phase(input int unsigned n_items,
                                    input logic [wfpa_pkg::CFG_W-1:0] count);
        logic [wfpa_pkg::IDX_W-1:0]  idx;
        logic [wfpa_pkg::SIZE_W-1:0] size;

        write_block_count(count);
        for (int unsigned i = 0; i < n_items; i++) begin
            if (i % 40 == 0)
                steady = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 99) < 45) begin
                if (count != 0 && count < wfpa_pkg::MAX_BLOCKS && $urandom_range(0, 4) != 0)
                    idx = wfpa_pkg::IDX_W'($urandom_range(0, count - 1));
                else
                    idx = wfpa_pkg::IDX_W'($urandom_range(0, wfpa_pkg::MAX_BLOCKS - 1));
                case ($urandom_range(0, 9))
                    0:       size = '0;
                    1:       size = '1;
                    2, 3:    size = wfpa_pkg::SIZE_W'(256 << $urandom_range(0, 2));
                    default: size = wfpa_pkg::SIZE_W'($urandom);
                endcase
                send_item(load_cmd(idx, size));
            end else begin
                case ($urandom_range(0, 19))
                    0:       size = '0;
                    1:       size = wfpa_pkg::SIZE_W'($urandom);
                    2:       size = blk_size[$urandom_range(0, wfpa_pkg::MAX_BLOCKS - 1)];
                    default: size = wfpa_pkg::SIZE_W'($urandom_range(0, 511));
                endcase
                send_item(alloc_cmd(size, wfpa_pkg::PNUM_W'($urandom)));
            end
        end
        steady = 1'b0;
    endtask

    task automatic test_random_traffic();
        logic [wfpa_pkg::CFG_W-1:0] counts [8];

        counts = '{6'd32, 6'd1, 6'd5, 6'd63, 6'd0, 6'd17, 6'd33, 6'd32};
        counts[7] = wfpa_pkg::CFG_W'($urandom_range(1, 63));
        foreach (counts[p])
            run_random_phase((counts[p] == 0) ? 50 : 150, counts[p]);
    endtask

    // Keep refilling one block with the largest size and placing the largest
    // process in it until used memory pins at its ceiling.
    task automatic test_used_saturation();
        write_block_count(6'd1);
        repeat (34) begin
            send_item(load_cmd(5'd0, 16'hFFFF));
            send_item(alloc_cmd(16'hFFFF, wfpa_pkg::PNUM_W'($urandom)));
        end
    endtask

    initial begin
        i_rst_n               <= 1'b0;
        i_cfg_we              <= 1'b0;
        i_cfg_data            <= '0;
        req_ch.valid          <= 1'b0;
        req_ch.req_type       <= wfpa_pkg::REQ_LOAD;
        req_ch.block_index    <= '0;
        req_ch.size_value     <= '0;
        req_ch.process_number <= '0;
        reset_shadow();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_table();
        test_worst_fit_choice();
        test_block_count_limits();
        test_random_traffic();
        test_used_saturation();

        wait_idle();
        if (error_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
